// ===== rtl/vrc_pkg.sv =====
package vrc_pkg;

    localparam int COUNTER_WIDTH_DEF = 64;
    localparam int KEY_COUNT         = 4096;
    localparam int KEY_W             = $clog2(KEY_COUNT);
    localparam int LEN_W             = 16;
    localparam int PORT_W            = 32;
    localparam int OUT_CNT_W         = 64;
    localparam int IN_TDATA_W        = 96;
    localparam int OUT_TDATA_W       = 224;
    localparam int TUSER_W           = 2;

    localparam logic [KEY_W-1:0] GLOBAL_KEY     = KEY_W'(KEY_COUNT - 1);
    localparam logic [LEN_W-1:0] ETH_HDR_LEN    = 16'd14;
    localparam logic [LEN_W-1:0] TAGGED_HDR_LEN = 16'd18;
    localparam logic [15:0]      TPID_CTAG      = 16'h8100;
    localparam logic [15:0]      TPID_STAG      = 16'h88A8;

    typedef enum logic [1:0] {
        OP_FRAME  = 2'd0,
        OP_WRITE  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_READ   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ACT_DROP     = 2'd0,
        ACT_REDIRECT = 2'd1,
        ACT_ACK      = 2'd2
    } t_action;

    // Controller to datapath.
    typedef struct packed {
        logic clear;
        logic accept;
        logic exec;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic clear_last;
    } t_sts;

endpackage

// ===== rtl/vrc_ram.sv =====
module vrc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/vrc_ctrl.sv =====
module vrc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    input  vrc_pkg::t_sts i_sts,
    output vrc_pkg::t_cmd o_cmd
);
    import vrc_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   ready;
    logic   accept;

    assign ready  = (r_state == ST_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign accept = i_s_axis_tvalid && ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Result register: load on execute, drop once taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_state == ST_EXEC) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.clear     = (r_state == ST_CLEAR);
    assign o_cmd.accept    = accept;
    assign o_cmd.exec      = (r_state == ST_EXEC);
    assign o_s_axis_tready = ready;
    assign o_m_axis_tvalid = r_out_valid;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC))
        else $error("accepted request not executed next cycle");

    a_no_ready_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_s_axis_tready)
        else $error("request accepted during clearing pass");

    a_out_free_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> !r_out_valid)
        else $error("execute would overwrite a pending result");

    a_exec_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |=> (r_state == ST_IDLE) && r_out_valid)
        else $error("execute did not post a result");

endmodule

// ===== rtl/vrc_dp.sv =====
module vrc_dp #(
    parameter int COUNTER_WIDTH = vrc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vrc_pkg::t_cmd                   i_cmd,
    output vrc_pkg::t_sts                   o_sts,
    input  logic [vrc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic [vrc_pkg::TUSER_W-1:0]     i_s_axis_tuser,
    output logic [vrc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic [vrc_pkg::TUSER_W-1:0]     o_m_axis_tuser
);
    import vrc_pkg::*;

    localparam int CW = COUNTER_WIDTH;

    // Request fields.
    t_opcode           s_opcode;
    logic [LEN_W-1:0]  s_len;
    logic [15:0]       s_etype;
    logic [15:0]       s_tci;
    logic [KEY_W-1:0]  s_key;
    logic [PORT_W-1:0] s_port;
    logic              s_tagged;
    logic              s_short;
    logic [KEY_W-1:0]  s_vid;
    logic [KEY_W-1:0]  s_raddr;

    // Captured request.
    t_opcode           r_opcode;
    logic [LEN_W-1:0]  r_len;
    logic [PORT_W-1:0] r_port;
    logic [KEY_W-1:0]  r_key;
    logic              r_short;

    // Key 4095 lives in registers.
    logic              r_g_valid;
    logic [PORT_W-1:0] r_g_port;
    logic [CW-1:0]     r_g_bytes;
    logic [CW-1:0]     r_g_pkts;
    logic [CW-1:0]     r_g_drops;

    logic [KEY_W-1:0]  r_clr_addr;

    logic [PORT_W:0]   ent_rd;
    logic [3*CW-1:0]   cnt_rd;
    logic              ent_we;
    logic              cnt_we;
    logic [KEY_W-1:0]  waddr;
    logic [PORT_W:0]   ent_wd;
    logic [3*CW-1:0]   cnt_wd;

    logic              glob;
    logic              sel_valid;
    logic [PORT_W-1:0] sel_port;
    logic [CW-1:0]     sel_bytes;
    logic [CW-1:0]     sel_pkts;
    logic [CW-1:0]     sel_drops;
    logic              g_redirect;
    logic              drop;
    logic              pass;
    logic [LEN_W:0]    len_inc;
    logic [1:0]        pkt_inc;
    logic [CW-1:0]     new_bytes;
    logic [CW-1:0]     new_pkts;
    logic [CW-1:0]     new_drops;

    logic [1:0]            r_out_action;
    logic [PORT_W-1:0]     r_out_port;
    logic [OUT_CNT_W-1:0]  r_out_bytes;
    logic [OUT_CNT_W-1:0]  r_out_pkts;
    logic [OUT_CNT_W-1:0]  r_out_drops;

    assign s_opcode = t_opcode'(i_s_axis_tuser[1:0]);
    assign s_len    = i_s_axis_tdata[15:0];
    assign s_etype  = i_s_axis_tdata[31:16];
    assign s_tci    = i_s_axis_tdata[47:32];
    assign s_key    = i_s_axis_tdata[59:48];
    assign s_port   = i_s_axis_tdata[91:60];

    // Short frames fall on VLAN 0; untagged frames are VLAN 0.
    assign s_tagged = (s_etype == TPID_CTAG) || (s_etype == TPID_STAG);
    assign s_short  = (s_len < ETH_HDR_LEN) || (s_tagged && (s_len < TAGGED_HDR_LEN));
    assign s_vid    = (s_tagged && !s_short) ? s_tci[KEY_W-1:0] : '0;
    assign s_raddr  = (s_opcode == OP_FRAME) ? s_vid : s_key;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_opcode <= s_opcode;
            r_len    <= s_len;
            r_port   <= s_port;
            r_key    <= s_raddr;
            r_short  <= s_short;
        end
    end

    always_comb begin
        glob       = (r_key == GLOBAL_KEY);
        sel_valid  = glob ? r_g_valid : ent_rd[PORT_W];
        sel_port   = glob ? r_g_port  : ent_rd[PORT_W-1:0];
        sel_bytes  = glob ? r_g_bytes : cnt_rd[CW-1:0];
        sel_pkts   = glob ? r_g_pkts  : cnt_rd[2*CW-1:CW];
        sel_drops  = glob ? r_g_drops : cnt_rd[3*CW-1:2*CW];
        g_redirect = r_g_valid && (r_g_port != '0);
        drop       = r_short || !sel_valid || (!g_redirect && (sel_port == '0));
        pass       = !drop;
        // A pass on key 4095 counts on the VLAN and on 4095 alike: count twice.
        len_inc    = (glob && pass) ? {r_len, 1'b0} : {1'b0, r_len};
        pkt_inc    = (glob && pass) ? 2'd2 : 2'd1;
        new_bytes  = sel_bytes + (pass ? CW'(len_inc) : '0);
        new_pkts   = sel_pkts + (pass ? CW'(pkt_inc) : '0);
        new_drops  = sel_drops + CW'(drop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_g_valid <= 1'b0;
            r_g_bytes <= '0;
            r_g_pkts  <= '0;
            r_g_drops <= '0;
        end else if (i_cmd.exec) begin
            case (r_opcode)
                OP_WRITE: begin
                    if (glob) begin
                        r_g_valid <= 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (glob) begin
                        r_g_valid <= 1'b0;
                    end
                end
                OP_FRAME: begin
                    if (glob) begin
                        r_g_bytes <= new_bytes;
                        r_g_pkts  <= new_pkts;
                        r_g_drops <= new_drops;
                    end else if (pass && g_redirect) begin
                        r_g_bytes <= r_g_bytes + CW'(r_len);
                        r_g_pkts  <= r_g_pkts + CW'(1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && glob && (r_opcode == OP_WRITE)) begin
            r_g_port <= r_port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + KEY_W'(1);
        end
    end

    assign o_sts.clear_last = (r_clr_addr == KEY_W'(KEY_COUNT - 1));

    assign waddr  = i_cmd.clear ? r_clr_addr : r_key;
    assign ent_we = i_cmd.clear || (i_cmd.exec && !glob &&
                    ((r_opcode == OP_WRITE) || (r_opcode == OP_REMOVE)));
    assign ent_wd = i_cmd.clear ? '0 : {(r_opcode == OP_WRITE), r_port};
    assign cnt_we = i_cmd.clear || (i_cmd.exec && !glob && (r_opcode == OP_FRAME));
    assign cnt_wd = i_cmd.clear ? '0 : {new_drops, new_pkts, new_bytes};

    vrc_ram #(
        .WIDTH (PORT_W + 1),
        .DEPTH (KEY_COUNT)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (waddr),
        .i_wdata (ent_wd),
        .i_re    (i_cmd.accept),
        .i_raddr (s_raddr),
        .o_rdata (ent_rd)
    );

    vrc_ram #(
        .WIDTH (3 * CW),
        .DEPTH (KEY_COUNT)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (waddr),
        .i_wdata (cnt_wd),
        .i_re    (i_cmd.accept),
        .i_raddr (s_raddr),
        .o_rdata (cnt_rd)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_bytes <= '0;
            r_out_pkts  <= '0;
            r_out_drops <= '0;
            r_out_port  <= '0;
            case (r_opcode)
                OP_FRAME: begin
                    r_out_action <= pass ? ACT_REDIRECT : ACT_DROP;
                    if (pass) begin
                        r_out_port <= g_redirect ? r_g_port : sel_port;
                    end
                end
                OP_READ: begin
                    r_out_action <= ACT_ACK;
                    r_out_bytes  <= OUT_CNT_W'(sel_bytes);
                    r_out_pkts   <= OUT_CNT_W'(sel_pkts);
                    r_out_drops  <= OUT_CNT_W'(sel_drops);
                end
                default: begin
                    r_out_action <= ACT_ACK;
                end
            endcase
        end
    end

    assign o_m_axis_tdata = {r_out_drops, r_out_pkts, r_out_bytes, r_out_port};
    assign o_m_axis_tuser = r_out_action;

endmodule

// ===== rtl/vlan_redirect_classifier.sv =====
// VLAN redirect classifier. Each request on the slave stream is one operation, selected
// by tuser: classify a frame header, write a table entry, remove a table entry, or read
// the byte, packet and drop counters of one key. Every request returns exactly one
// result on the master stream, in order. A frame whose VLAN entry is valid is steered to
// the global redirect port when entry 4095 is valid with a nonzero port (then counted on
// its VLAN and on 4095), else to its VLAN's nonzero port; any other frame is dropped and
// the drop counted on its VLAN; short frames count as drops on VLAN 0. In the accept
// cycle a request launches the registered read of the entry and counter RAMs; the next
// cycle does the read-modify-write and loads the result register, and no new request is
// taken until that is done. A result that still waits holds off the next request until
// the cycle in which it is taken. After reset a clearing pass zeroes the table and
// counters, one key per cycle; no request is accepted until it ends. Key 4095 is held in
// registers so a global redirect costs a single RAM write.
module vlan_redirect_classifier #(
    parameter int COUNTER_WIDTH = vrc_pkg::COUNTER_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // frame_length, ether_type, tag_control, table_key, table_port, zero pad
    input  logic [vrc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // opcode
    input  logic [vrc_pkg::TUSER_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // egress_port, count_bytes, count_packets, count_drops
    output logic [vrc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // action
    output logic [vrc_pkg::TUSER_W-1:0]     o_m_axis_tuser
);
    import vrc_pkg::*;

    // Command and status between controller and datapath.
    t_cmd cmd;
    t_sts sts;

    // Sequence requests: clearing pass, accept, execute.
    vrc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .i_sts           (sts),
        .o_cmd           (cmd)
    );

    // Hold the table, the counters and the result register.
    vrc_dp #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

endmodule
